// ===== sv/dlpc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the combination-lock controller: phase codes, motor codes,
// register indexes and the result record. Used by every module in sv/.
package dlpc_pkg;

	localparam int unsigned DIGITS_DEF = 5;
	localparam logic [7:0] OPEN_SECONDS_RST = 8'd15;
	localparam logic [7:0] ALARM_SECONDS_RST = 8'd60;
	localparam logic [7:0] SEC_MAX = 8'd255;

	typedef enum logic [2:0] {
		PH_CREATE  = 3'd0,
		PH_OPTION  = 3'd1,
		PH_VERIFY  = 3'd2,
		PH_OPENING = 3'd3,
		PH_MOTION  = 3'd4,
		PH_CLOSING = 3'd5,
		PH_ALARM   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		MOTOR_STOP = 2'd0,
		MOTOR_FWD  = 2'd1,
		MOTOR_REV  = 2'd2
	} motor_t;

	localparam logic REG_OPEN_SECONDS = 1'b0;
	localparam logic REG_ALARM_SECONDS = 1'b1;

	localparam logic MODE_BYTE = 1'b0;

	typedef struct packed {
		logic       reply_valid;
		logic       reply_byte;
		logic [1:0] motor_drive;
		logic       alarm_on;
		logic [2:0] phase;
	} result_t;

endpackage

// ===== sv/dlpc_core.sv =====
`timescale 1ns / 1ps
// Lock state machine: phase, digit counters, code storage and second timer.
// Computes the result of one request in the cycle it is taken. Uses dlpc_pkg.
module dlpc_core #(
	parameter int unsigned DIGITS = dlpc_pkg::DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              mode,
	input  logic [7:0]        rx_byte,
	input  logic              pir_level,
	input  logic [7:0]        open_seconds,
	input  logic [7:0]        alarm_seconds,
	output dlpc_pkg::result_t res
);

	localparam int unsigned CW = $clog2(2 * DIGITS + 1);
	localparam int unsigned IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam logic [CW-1:0] DIG_N = CW'(DIGITS);
	localparam logic [CW-1:0] DIG_2N = CW'(2 * DIGITS);

	dlpc_pkg::phase_t phase_q, phase_nxt;
	logic [CW-1:0] dcnt_q, dcnt_nxt, dcnt_inc, dcnt_hi;
	logic          mism_q, mism_nxt;
	logic          chg_q, chg_nxt;
	logic          retry_q, retry_nxt;
	logic [7:0]    sec_q, sec_nxt, sec_inc;
	logic [7:0]    entry_q [DIGITS];
	logic [7:0]    code_q [DIGITS];
	logic          entry_we, code_copy;
	logic [IW-1:0] entry_idx;
	logic          rvalid, rbyte;
	logic          cmp_ne_entry, cmp_ne_code;

	assign dcnt_inc = dcnt_q + CW'(1);
	assign dcnt_hi  = dcnt_q - DIG_N;
	assign sec_inc  = (sec_q == dlpc_pkg::SEC_MAX) ? sec_q : sec_q + 8'd1;
	assign entry_idx = dcnt_q[IW-1:0];
	assign cmp_ne_entry = (entry_q[dcnt_hi[IW-1:0]] != rx_byte);
	assign cmp_ne_code  = (code_q[dcnt_q[IW-1:0]] != rx_byte);

	always_comb begin
		phase_nxt = phase_q;
		dcnt_nxt  = dcnt_q;
		mism_nxt  = mism_q;
		chg_nxt   = chg_q;
		retry_nxt = retry_q;
		sec_nxt   = sec_q;
		entry_we  = 1'b0;
		code_copy = 1'b0;
		rvalid    = 1'b0;
		rbyte     = 1'b0;
		if (mode == dlpc_pkg::MODE_BYTE) begin
			unique case (phase_q)
				dlpc_pkg::PH_CREATE: begin
					if (dcnt_q < DIG_N) begin
						entry_we = 1'b1;
					end else if (cmp_ne_entry) begin
						mism_nxt = 1'b1;
					end
					dcnt_nxt = dcnt_inc;
					if (dcnt_inc >= DIG_2N) begin
						rvalid = 1'b1;
						rbyte  = ~mism_nxt;
						if (!mism_nxt) begin
							code_copy = 1'b1;
							phase_nxt = dlpc_pkg::PH_OPTION;
						end
						dcnt_nxt = '0;
						mism_nxt = 1'b0;
					end
				end
				dlpc_pkg::PH_VERIFY: begin
					if (dcnt_q < DIG_N && cmp_ne_code) begin
						mism_nxt = 1'b1;
					end
					dcnt_nxt = dcnt_inc;
					if (dcnt_inc >= DIG_N) begin
						rvalid = 1'b1;
						rbyte  = ~mism_nxt;
						if (!mism_nxt) begin
							phase_nxt = chg_q ? dlpc_pkg::PH_CREATE : dlpc_pkg::PH_OPENING;
							if (!chg_q) begin
								sec_nxt = 8'd0;
							end
							retry_nxt = 1'b0;
						end else if (!retry_q) begin
							retry_nxt = 1'b1;
						end else begin
							retry_nxt = 1'b0;
							phase_nxt = dlpc_pkg::PH_ALARM;
							sec_nxt   = 8'd0;
						end
						dcnt_nxt = '0;
						mism_nxt = 1'b0;
					end
				end
				dlpc_pkg::PH_OPENING, dlpc_pkg::PH_MOTION,
				dlpc_pkg::PH_CLOSING, dlpc_pkg::PH_ALARM: begin
					phase_nxt = phase_q;
				end
				default: begin
					// Option phase; the unused code behaves the same way.
					chg_nxt   = rx_byte[0];
					phase_nxt = dlpc_pkg::PH_VERIFY;
					dcnt_nxt  = '0;
					mism_nxt  = 1'b0;
					retry_nxt = 1'b0;
				end
			endcase
		end else begin
			unique case (phase_q)
				dlpc_pkg::PH_OPENING: begin
					if (sec_inc >= open_seconds) begin
						phase_nxt = dlpc_pkg::PH_MOTION;
						sec_nxt   = 8'd0;
					end else begin
						sec_nxt = sec_inc;
					end
				end
				dlpc_pkg::PH_MOTION: begin
					if (!pir_level) begin
						rvalid    = 1'b1;
						phase_nxt = dlpc_pkg::PH_CLOSING;
						sec_nxt   = 8'd0;
					end
				end
				dlpc_pkg::PH_CLOSING: begin
					if (sec_inc >= open_seconds) begin
						phase_nxt = dlpc_pkg::PH_OPTION;
						sec_nxt   = 8'd0;
					end else begin
						sec_nxt = sec_inc;
					end
				end
				dlpc_pkg::PH_ALARM: begin
					if (sec_inc >= alarm_seconds) begin
						phase_nxt = dlpc_pkg::PH_OPTION;
						sec_nxt   = 8'd0;
					end else begin
						sec_nxt = sec_inc;
					end
				end
				dlpc_pkg::PH_CREATE, dlpc_pkg::PH_VERIFY: begin
					phase_nxt = phase_q;
				end
				default: begin
					// Ticks are ignored while a code is entered; a stray code
					// settles into the option phase.
					phase_nxt = dlpc_pkg::PH_OPTION;
				end
			endcase
		end

		res.reply_valid = rvalid;
		res.reply_byte  = rbyte;
		res.motor_drive = (phase_nxt == dlpc_pkg::PH_OPENING) ? dlpc_pkg::MOTOR_FWD :
			(phase_nxt == dlpc_pkg::PH_CLOSING) ? dlpc_pkg::MOTOR_REV : dlpc_pkg::MOTOR_STOP;
		res.alarm_on    = (phase_nxt == dlpc_pkg::PH_ALARM);
		res.phase       = phase_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dlpc_pkg::PH_CREATE;
			dcnt_q  <= '0;
			mism_q  <= 1'b0;
			chg_q   <= 1'b0;
			retry_q <= 1'b0;
			sec_q   <= 8'd0;
		end else if (take) begin
			phase_q <= phase_nxt;
			dcnt_q  <= dcnt_nxt;
			mism_q  <= mism_nxt;
			chg_q   <= chg_nxt;
			retry_q <= retry_nxt;
			sec_q   <= sec_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (take && entry_we) begin
			entry_q[entry_idx] <= rx_byte;
		end
		if (take && code_copy) begin
			code_q <= entry_q;
		end
	end

endmodule

// ===== sv/dlpc_outq.sv =====
`timescale 1ns / 1ps
// Two-entry result buffer between the state machine and the output channel.
// Lets a new request in while a finished result waits. Uses dlpc_pkg.
module dlpc_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dlpc_pkg::result_t din,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output dlpc_pkg::result_t dout
);

	dlpc_pkg::result_t ent0_q, ent1_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign pop       = out_valid && !out_stall;
	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign dout      = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					ent0_q <= din;
				end else begin
					ent1_q <= din;
				end
			end
			2'b01: begin
				ent0_q <= ent1_q;
			end
			2'b11: begin
				// Push with pop only happens with one entry held.
				ent0_q <= din;
			end
			default: begin
				ent0_q <= ent0_q;
			end
		endcase
	end

endmodule

// ===== sv/door_lock_password_controller_top.sv =====
`timescale 1ns / 1ps
// Top level of the combination-lock controller: configuration registers,
// state machine (dlpc_core) and result buffer (dlpc_outq). Uses dlpc_pkg.
//
// Usage:
// Each input request is a received byte (mode 0, rx_byte) or a one-second
// tick (mode 1) that carries the motion level pir_level. It is taken at a
// rising edge with in_valid high and in_stall low. Every request gives
// exactly one result on the output channel, taken with out_valid high and
// out_stall low.
// The state machine updates and the result is written to a two-entry buffer
// in the cycle the request is taken; out_valid rises on the next edge.
// Throughput is one request per cycle while in_stall is low, set by the
// single state update per request.
// When the receiver stalls, the buffer holds up to two results; in_stall is
// raised once both entries are full and drops as soon as one is taken.
// Reset (arst_n low) puts the block in the create phase with all counters
// clear, empties the buffer and loads open_seconds = 15 and alarm_seconds =
// 60. The configuration port writes register cfg_index (0 open_seconds,
// 1 alarm_seconds) from cfg_data whenever cfg_we is high.
module door_lock_password_controller_top #(
	parameter int unsigned DIGITS = dlpc_pkg::DIGITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] rx_byte,
	input  logic       pir_level,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       reply_valid,
	output logic       reply_byte,
	output logic [1:0] motor_drive,
	output logic       alarm_on,
	output logic [2:0] phase
);

	logic [7:0]        open_sec_q, alarm_sec_q;
	logic              take;
	dlpc_pkg::result_t core_res, q_res;

	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_sec_q  <= dlpc_pkg::OPEN_SECONDS_RST;
			alarm_sec_q <= dlpc_pkg::ALARM_SECONDS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dlpc_pkg::REG_OPEN_SECONDS:  open_sec_q  <= cfg_data;
				dlpc_pkg::REG_ALARM_SECONDS: alarm_sec_q <= cfg_data;
				default:                     open_sec_q  <= open_sec_q;
			endcase
		end
	end

	dlpc_core #(
		.DIGITS(DIGITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.mode         (mode),
		.rx_byte      (rx_byte),
		.pir_level    (pir_level),
		.open_seconds (open_sec_q),
		.alarm_seconds(alarm_sec_q),
		.res          (core_res)
	);

	dlpc_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.din      (core_res),
		.full     (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dout     (q_res)
	);

	assign reply_valid = q_res.reply_valid;
	assign reply_byte  = q_res.reply_byte;
	assign motor_drive = q_res.motor_drive;
	assign alarm_on    = q_res.alarm_on;
	assign phase       = q_res.phase;

	// The buffer only fills up when results are waiting.
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	// A request taken into an empty buffer shows up on the next edge.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !out_valid) |=> out_valid)
		else $error("result missing one cycle after request");

	// Reverse drive and alarm follow the phase reported with them.
	a_outputs_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((motor_drive == dlpc_pkg::MOTOR_REV) ==
			(phase == dlpc_pkg::PH_CLOSING)) &&
			(alarm_on == (phase == dlpc_pkg::PH_ALARM)))
		else $error("motor or alarm disagrees with phase");

	// A silent result never carries a reply value.
	a_reply_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !reply_valid) |-> !reply_byte)
		else $error("reply byte set without reply");

endmodule
